// ----- sv/swin_pkg.sv -----
// Shared types and codes of the sliding-window sender.
// No dependencies; the result interface and the top level use it by scoped names.
package swin_pkg;

    localparam int IDX_W = 23;
    localparam int LEN_W = 11;
    localparam int CFG_W = 32;

    typedef logic [IDX_W-1:0] t_idx;

    localparam t_idx IDX_MAX = '1;

    // Kinds of input words.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_ACK   = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;

    // Kinds of result words.
    localparam logic [1:0] EV_SEND   = 2'd0;
    localparam logic [1:0] EV_RESEND = 2'd1;
    localparam logic [1:0] EV_DONE   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_WINDOW  = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_FILE    = 2'd2;
    localparam logic [1:0] REG_BASE    = 2'd3;

endpackage

// ----- sv/swin_req_if.sv -----
// Input channel of the sliding-window sender: tick, ack and start words.
// No dependencies.
interface swin_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] ack_num;
    logic        ack_ok;

    modport source (output valid, kind, ack_num, ack_ok, input ready);
    modport sink   (input valid, kind, ack_num, ack_ok, output ready);
endinterface

// ----- sv/swin_res_if.sv -----
// Result channel of the sliding-window sender: send, resend and done words.
// Depends on swin_pkg for field widths.
interface swin_res_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 event_res;
    logic [swin_pkg::IDX_W-1:0] packet_index;
    logic [31:0]                seq_num;
    logic [31:0]                data_offset;
    logic [swin_pkg::LEN_W-1:0] data_length;
    logic                       last;

    modport source (output valid, event_res, packet_index, seq_num, data_offset,
                    data_length, last, input ready);
    modport sink   (input valid, event_res, packet_index, seq_num, data_offset,
                    data_length, last, output ready);
endinterface

// ----- sv/sliding_window_sender.sv -----
// Sliding-window sender: one input word at a time; a new word is accepted only once the last
// one is finished. A tick scans the outstanding slots, an accepted ack marks its slot and then
// checks slots for edge advance, and each packet is sent in turn; the first word after a
// file_size write first runs the reciprocal division. Output stalls hold the word.
// Reset is synchronous, active low; it clears control state and the slot valid bits at once.
// Depends on swin_pkg, swin_req_if and swin_res_if.
module sliding_window_sender #(
    parameter int MAX_WINDOW    = 32,
    parameter int SEGMENT_BYTES = 1024,
    parameter int TIMER_BITS    = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [swin_pkg::CFG_W-1:0]  i_cfg_data,
    swin_req_if.sink                    i_req,
    swin_res_if.source                  o_res
);

    // Slot index width; packet p lives in slot p mod MAX_WINDOW, tracked by
    // wrapping slot counters so that no modulo of a packet index is needed.
    localparam int SW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    // Remainder width of the division by SEGMENT_BYTES.
    localparam int RW = $clog2(SEGMENT_BYTES) + 2;
    // Width in which timer and timeout are compared.
    localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    // Reciprocal of the segment size: with L = ceil(log2 SEGMENT_BYTES) and
    // M = ceil(2^(32+L) / SEGMENT_BYTES), floor(x / SEGMENT_BYTES) equals
    // (x * M) >> (32+L) for every 32-bit x.
    localparam int          SEG_L   = $clog2(SEGMENT_BYTES);
    localparam logic [63:0] SEG_D64 = 64'(SEGMENT_BYTES);
    localparam logic [33:0] SEG_RCP = 34'(((64'd1 << (32 + SEG_L)) + SEG_D64 - 64'd1) / SEG_D64);

    typedef logic [SW-1:0]       t_slot;
    typedef logic [TIMER_BITS:0] t_entry;   // {acked, timer}

    localparam logic [SW:0]           MW_S     = (SW+1)'(MAX_WINDOW);
    localparam t_slot                 MW_LAST  = SW'(MAX_WINDOW - 1);
    localparam logic [TIMER_BITS-1:0] TMAX     = '1;
    localparam logic [6:0]            WIN_MAX  = 7'(MAX_WINDOW);
    localparam logic [swin_pkg::LEN_W-1:0] SEG_LEN = swin_pkg::LEN_W'(SEGMENT_BYTES);
    localparam logic [31:0]           SEG_MUL  = 32'(SEGMENT_BYTES);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_EVENT,
        S_ADV_RD,
        S_ADV_CHK,
        S_DONE_CHK,
        S_TICK_CHK,
        S_SEND,
        S_FIN
    } t_state;

    function automatic t_slot slot_inc(input t_slot s);
        t_slot r;
        r = (s == MW_LAST) ? '0 : s + t_slot'(1);
        return r;
    endfunction

    // Configuration registers.
    logic [5:0]  r_window,  n_window;
    logic [15:0] r_timeout, n_timeout;
    logic [31:0] r_file,    n_file;
    logic [31:0] r_base,    n_base;

    // Control state.
    t_state          r_state, n_state;
    logic [31:0]     r_div_q, n_div_q;      // quotient
    logic [RW-1:0]   r_div_r, n_div_r;      // remainder
    logic [1:0]      r_div_cnt, n_div_cnt;
    logic            r_dirty, n_dirty;      // file_size changed since last division
    swin_pkg::t_idx  r_next, n_next;
    swin_pkg::t_idx  r_old, n_old;
    swin_pkg::t_idx  r_total, n_total;
    t_slot           r_next_slot, n_next_slot;
    t_slot           r_old_slot, n_old_slot;
    logic            r_active, n_active;
    logic [MAX_WINDOW-1:0] r_valid, n_valid;
    logic            r_pend_v, n_pend_v;
    logic            r_out_v, n_out_v;

    // Payload registers.
    logic [1:0]      r_kind, n_kind;
    logic [31:0]     r_ack_num, n_ack_num;
    logic            r_ack_ok, n_ack_ok;
    logic [31:0]     r_div_x, n_div_x;      // dividend
    logic [65:0]     r_div_acc, n_div_acc;  // dividend times reciprocal
    swin_pkg::t_idx  r_ptr, n_ptr;
    t_slot           r_ptr_slot, n_ptr_slot;
    logic [1:0]      r_pend_ev, n_pend_ev;
    swin_pkg::t_idx  r_pend_idx, n_pend_idx;
    logic [1:0]      r_out_ev, n_out_ev;
    swin_pkg::t_idx  r_out_idx, n_out_idx;
    logic [31:0]     r_out_seq, n_out_seq;
    logic [31:0]     r_out_off, n_out_off;
    logic [swin_pkg::LEN_W-1:0] r_out_len, n_out_len;
    logic            r_out_last, n_out_last;

    // Slot memory: acked flag and retransmit timer of each window slot.
    t_entry r_mem [MAX_WINDOW];
    t_entry r_rd_data;
    logic   mem_we;
    t_slot  mem_waddr;
    t_entry mem_wdata;
    logic   mem_re;
    t_slot  mem_raddr;

    // Working signals.
    logic            accept;
    logic            out_free;
    logic            can_push;
    logic            push;
    logic [1:0]      push_ev;
    swin_pkg::t_idx  push_idx;
    logic            fin;
    logic            out_load;
    logic            out_last;
    logic [15:0]     div_half;
    logic [49:0]     div_part;
    logic [31:0]     div_qd;
    logic [31:0]     ack_rel;
    logic [31:0]     ack_p;
    logic            ack_hit;
    swin_pkg::t_idx  ack_d;
    logic [SW:0]     ack_sum;
    t_slot           ack_slot;
    logic            ent_acked;
    logic [TIMER_BITS-1:0] ent_tmr;
    logic [TIMER_BITS-1:0] ent_tmr_inc;
    logic            tmr_fire;
    logic [6:0]      win_eff;
    swin_pkg::t_idx  outstanding;
    logic            send_ok;
    logic [23:0]     idx_plus;
    logic [31:0]     rem32;

    assign accept    = i_req.valid && i_req.ready;
    assign out_free  = !r_out_v || o_res.ready;
    assign can_push  = !r_pend_v || out_free;

    // Division by the segment size: the dividend is multiplied by the reciprocal
    // one half-word per cycle, then the remainder follows from the quotient.
    assign div_half = (r_div_cnt == 2'd0) ? r_div_x[15:0] : r_div_x[31:16];
    assign div_part = {34'b0, div_half} * {16'b0, SEG_RCP};
    assign div_qd   = r_div_q * SEG_MUL;

    // Ack decoding: packet index of the ack and its slot relative to the base edge.
    assign ack_rel  = r_ack_num - r_base;
    assign ack_p    = ack_rel - 32'd1;
    assign ack_hit  = r_active && r_ack_ok && (ack_rel != 32'd0)
                      && (ack_p >= {9'b0, r_old}) && (ack_p < {9'b0, r_next});
    assign ack_d    = ack_p[swin_pkg::IDX_W-1:0] - r_old;
    assign ack_sum  = {1'b0, r_old_slot} + {1'b0, ack_d[SW-1:0]};
    assign ack_slot = (ack_sum >= MW_S) ? t_slot'(ack_sum - MW_S) : ack_sum[SW-1:0];

    // The entry just read; a slot whose valid bit is clear reads as all zero.
    assign ent_acked   = r_valid[r_ptr_slot] & r_rd_data[TIMER_BITS];
    assign ent_tmr     = r_valid[r_ptr_slot] ? r_rd_data[TIMER_BITS-1:0] : '0;
    assign ent_tmr_inc = (ent_tmr == TMAX) ? ent_tmr : ent_tmr + 1'b1;
    assign tmr_fire    = (CW'(ent_tmr_inc) >= CW'(r_timeout));

    // Effective window: zero acts as one, anything above the slot count is clipped.
    assign win_eff     = (r_window == 6'd0) ? 7'd1 :
                         (({1'b0, r_window} > WIN_MAX) ? WIN_MAX : {1'b0, r_window});
    assign outstanding = r_next - r_old;
    assign send_ok     = r_active && (outstanding < {16'b0, win_eff}) && (r_next < r_total);

    assign idx_plus = {1'b0, r_pend_idx} + 24'd1;
    assign rem32    = 32'(r_div_r);

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_window    = r_window;
        n_timeout   = r_timeout;
        n_file      = r_file;
        n_base      = r_base;
        n_state     = r_state;
        n_div_q     = r_div_q;
        n_div_r     = r_div_r;
        n_div_cnt   = r_div_cnt;
        n_div_x     = r_div_x;
        n_div_acc   = r_div_acc;
        n_dirty     = r_dirty;
        n_next      = r_next;
        n_old       = r_old;
        n_total     = r_total;
        n_next_slot = r_next_slot;
        n_old_slot  = r_old_slot;
        n_active    = r_active;
        n_valid     = r_valid;
        n_pend_v    = r_pend_v;
        n_kind      = r_kind;
        n_ack_num   = r_ack_num;
        n_ack_ok    = r_ack_ok;
        n_ptr       = r_ptr;
        n_ptr_slot  = r_ptr_slot;
        n_pend_ev   = r_pend_ev;
        n_pend_idx  = r_pend_idx;
        n_out_ev    = r_out_ev;
        n_out_idx   = r_out_idx;
        n_out_seq   = r_out_seq;
        n_out_off   = r_out_off;
        n_out_len   = r_out_len;
        n_out_last  = r_out_last;

        mem_we    = 1'b0;
        mem_waddr = r_ptr_slot;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = r_old_slot;

        push     = 1'b0;
        push_ev  = swin_pkg::EV_SEND;
        push_idx = r_next;
        fin      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kind    = i_req.kind;
                    n_ack_num = i_req.ack_num;
                    n_ack_ok  = i_req.ack_ok;
                    if (r_dirty) begin
                        n_div_x   = r_file;
                        n_div_cnt = '0;
                        n_dirty   = 1'b0;
                        n_state   = S_DIV;
                    end else begin
                        n_state = S_EVENT;
                    end
                end
            end
            S_DIV: begin
                n_div_cnt = r_div_cnt + 2'd1;
                case (r_div_cnt)
                    2'd0: n_div_acc = {16'b0, div_part};
                    2'd1: n_div_acc = r_div_acc + {div_part, 16'b0};
                    2'd2: n_div_q   = 32'(r_div_acc >> (32 + SEG_L));
                    default: begin
                        n_div_r = RW'(r_div_x - div_qd);
                        n_state = S_EVENT;
                    end
                endcase
            end
            S_EVENT: begin
                n_state = S_SEND;
                case (r_kind)
                    swin_pkg::KIND_START: begin
                        if (r_div_q >= {9'b0, swin_pkg::IDX_MAX}) begin
                            n_total = swin_pkg::IDX_MAX;
                        end else begin
                            n_total = r_div_q[swin_pkg::IDX_W-1:0] + 1'b1;
                        end
                        n_next      = '0;
                        n_old       = '0;
                        n_next_slot = '0;
                        n_old_slot  = '0;
                        n_valid     = '0;
                        n_active    = 1'b1;
                    end
                    swin_pkg::KIND_ACK: begin
                        if (ack_hit) begin
                            mem_we            = 1'b1;
                            mem_waddr         = ack_slot;
                            mem_wdata         = {1'b1, {TIMER_BITS{1'b0}}};
                            n_valid[ack_slot] = 1'b1;
                            n_state           = S_ADV_RD;
                        end
                    end
                    swin_pkg::KIND_TICK: begin
                        if (r_active && (r_old < r_next)) begin
                            mem_re     = 1'b1;
                            mem_raddr  = r_old_slot;
                            n_ptr      = r_old;
                            n_ptr_slot = r_old_slot;
                            n_state    = S_TICK_CHK;
                        end
                    end
                    default: begin
                        n_state = S_SEND;
                    end
                endcase
            end
            S_ADV_RD: begin
                // The ack write has landed, so this read sees it.
                n_ptr_slot = r_old_slot;
                if (r_old < r_next) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_old_slot;
                    n_state   = S_ADV_CHK;
                end else begin
                    n_state = S_DONE_CHK;
                end
            end
            S_ADV_CHK: begin
                if (ent_acked) begin
                    n_valid[r_old_slot] = 1'b0;
                    n_old      = r_old + 1'b1;
                    n_old_slot = slot_inc(r_old_slot);
                    n_ptr_slot = slot_inc(r_old_slot);
                    if (r_old + 1'b1 < r_next) begin
                        mem_re    = 1'b1;
                        mem_raddr = slot_inc(r_old_slot);
                    end else begin
                        n_state = S_DONE_CHK;
                    end
                end else begin
                    n_state = S_DONE_CHK;
                end
            end
            S_DONE_CHK: begin
                if (r_old >= r_total) begin
                    if (can_push) begin
                        push     = 1'b1;
                        push_ev  = swin_pkg::EV_DONE;
                        push_idx = '0;
                        n_active = 1'b0;
                        n_state  = S_SEND;
                    end
                end else begin
                    n_state = S_SEND;
                end
            end
            S_TICK_CHK: begin
                // Stall only when this slot fires and no result can be taken.
                if (ent_acked || !tmr_fire || can_push) begin
                    if (!ent_acked) begin
                        if (tmr_fire) begin
                            push                = 1'b1;
                            push_ev             = swin_pkg::EV_RESEND;
                            push_idx            = r_ptr;
                            n_valid[r_ptr_slot] = 1'b0;
                        end else begin
                            mem_we              = 1'b1;
                            mem_waddr           = r_ptr_slot;
                            mem_wdata           = {1'b0, ent_tmr_inc};
                            n_valid[r_ptr_slot] = 1'b1;
                        end
                    end
                    if (r_ptr + 1'b1 < r_next) begin
                        mem_re     = 1'b1;
                        mem_raddr  = slot_inc(r_ptr_slot);
                        n_ptr      = r_ptr + 1'b1;
                        n_ptr_slot = slot_inc(r_ptr_slot);
                    end else begin
                        n_state = S_SEND;
                    end
                end
            end
            S_SEND: begin
                if (send_ok) begin
                    if (can_push) begin
                        push                 = 1'b1;
                        push_ev              = swin_pkg::EV_SEND;
                        push_idx             = r_next;
                        n_valid[r_next_slot] = 1'b0;
                        n_next               = r_next + 1'b1;
                        n_next_slot          = slot_inc(r_next_slot);
                    end
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_pend_v || out_free) begin
                    fin     = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A new result pushes the held one out; the held one is marked last
        // only when the word finishes.
        out_load = 1'b0;
        out_last = 1'b0;
        if (push) begin
            out_load   = r_pend_v;
            n_pend_v   = 1'b1;
            n_pend_ev  = push_ev;
            n_pend_idx = push_idx;
        end else if (fin && r_pend_v) begin
            out_load = 1'b1;
            out_last = 1'b1;
            n_pend_v = 1'b0;
        end

        n_out_v = out_load || (r_out_v && !o_res.ready);
        if (out_load) begin
            n_out_ev   = r_pend_ev;
            n_out_last = out_last;
            if (r_pend_ev == swin_pkg::EV_DONE) begin
                n_out_idx = '0;
                n_out_seq = '0;
                n_out_off = '0;
                n_out_len = '0;
            end else begin
                n_out_idx = r_pend_idx;
                n_out_seq = r_base + {9'b0, r_pend_idx};
                n_out_off = 32'({9'b0, r_pend_idx} * SEG_MUL);
                n_out_len = (idx_plus >= {1'b0, r_total}) ?
                            rem32[swin_pkg::LEN_W-1:0] : SEG_LEN;
            end
        end

        if (i_cfg_we) begin
            case (i_cfg_idx)
                swin_pkg::REG_WINDOW:  n_window  = i_cfg_data[5:0];
                swin_pkg::REG_TIMEOUT: n_timeout = i_cfg_data[15:0];
                swin_pkg::REG_FILE: begin
                    n_file  = i_cfg_data;
                    n_dirty = 1'b1;
                end
                swin_pkg::REG_BASE:    n_base    = i_cfg_data;
                default:               n_base    = r_base;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= 6'd4;
            r_timeout   <= 16'd1000;
            r_file      <= '0;
            r_base      <= '0;
            r_state     <= S_IDLE;
            r_div_q     <= '0;
            r_div_r     <= '0;
            r_div_cnt   <= '0;
            r_dirty     <= 1'b0;
            r_next      <= '0;
            r_old       <= '0;
            r_total     <= '0;
            r_next_slot <= '0;
            r_old_slot  <= '0;
            r_active    <= 1'b0;
            r_valid     <= '0;
            r_pend_v    <= 1'b0;
            r_out_v     <= 1'b0;
        end else begin
            r_window    <= n_window;
            r_timeout   <= n_timeout;
            r_file      <= n_file;
            r_base      <= n_base;
            r_state     <= n_state;
            r_div_q     <= n_div_q;
            r_div_r     <= n_div_r;
            r_div_cnt   <= n_div_cnt;
            r_dirty     <= n_dirty;
            r_next      <= n_next;
            r_old       <= n_old;
            r_total     <= n_total;
            r_next_slot <= n_next_slot;
            r_old_slot  <= n_old_slot;
            r_active    <= n_active;
            r_valid     <= n_valid;
            r_pend_v    <= n_pend_v;
            r_out_v     <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_ack_num  <= n_ack_num;
        r_ack_ok   <= n_ack_ok;
        r_div_x    <= n_div_x;
        r_div_acc  <= n_div_acc;
        r_ptr      <= n_ptr;
        r_ptr_slot <= n_ptr_slot;
        r_pend_ev  <= n_pend_ev;
        r_pend_idx <= n_pend_idx;
        r_out_ev   <= n_out_ev;
        r_out_idx  <= n_out_idx;
        r_out_seq  <= n_out_seq;
        r_out_off  <= n_out_off;
        r_out_len  <= n_out_len;
        r_out_last <= n_out_last;
    end

    // Slot memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    assign o_res.valid        = r_out_v;
    assign o_res.event_res    = r_out_ev;
    assign o_res.packet_index = r_out_idx;
    assign o_res.seq_num      = r_out_seq;
    assign o_res.data_offset  = r_out_off;
    assign o_res.data_length  = r_out_len;
    assign o_res.last         = r_out_last;

endmodule
